/* design/hfdds_pkg.sv */
// Shared types and constants for the Hilbert FIR Doppler direction splitter.
package hfdds_pkg;

	localparam int CMD_W       = 2;
	localparam int TAP_CNT_W   = 7;
	localparam int COEF_IDX_W  = 6;
	localparam int MAX_TAPS    = 64;

	localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

	localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 7'd64;

	// controller -> datapath
	typedef struct packed {
		logic                 load_coef;  // write coefficient slot
		logic                 clear_hist; // drop Q history, rewind write slot
		logic                 push;       // store new Q, arm pointers, clear accumulator
		logic [TAP_CNT_W-1:0] taps;       // clamped tap count for this sample
		logic                 issue;      // one tap read into the MAC pipe
		logic                 finish;     // load result register
	} dp_cmd_t;

endpackage

/* design/hfdds_ctrl.sv */
// Sequencer for the Hilbert FIR: command decode, tap counting and result hand-off.
module hfdds_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hfdds_pkg::TAP_CNT_W-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [hfdds_pkg::CMD_W-1:0]    cmd,
	input  logic                           res_free,
	output hfdds_pkg::dp_cmd_t             dp_cmd
);
	import hfdds_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [TAP_CNT_W-1:0] tap_count_q;
	logic [TAP_CNT_W-1:0] cnt_q;
	logic                 drain_q;
	logic [TAP_CNT_W-1:0] taps;
	logic                 accept;

	// zero means one tap; above the store depth saturates
	always_comb begin
		if (tap_count_q == '0) begin
			taps = TAP_CNT_W'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps = TAP_CNT_W'(MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		dp_cmd            = '0;
		dp_cmd.taps       = taps;
		dp_cmd.load_coef  = accept && (cmd == CMD_LOAD_COEF);
		dp_cmd.clear_hist = accept && (cmd == CMD_CLEAR);
		dp_cmd.push       = accept && (cmd == CMD_SAMPLE);
		dp_cmd.issue      = (state_q == ST_RUN);
		dp_cmd.finish     = (state_q == ST_DONE) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_RESET;
		end else if (cfg_wr_en) begin
			tap_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_SAMPLE)) begin
						state_q <= ST_RUN;
						cnt_q   <= taps;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - TAP_CNT_W'(1);
					if (cnt_q == TAP_CNT_W'(1)) begin
						state_q <= ST_DRAIN;
						drain_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					// product stage, then accumulate
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/hfdds_dp.sv */
// Datapath: Q history and coefficient stores, MAC pipe, rounding, saturation, result register.
module hfdds_dp #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hfdds_pkg::dp_cmd_t               dp_cmd,
	output logic                             res_free,
	input  logic signed [SAMPLE_BITS-1:0]    i_sample,
	input  logic signed [SAMPLE_BITS-1:0]    q_sample,
	input  logic [hfdds_pkg::COEF_IDX_W-1:0] coef_index,
	input  logic signed [COEF_FRAC_BITS:0]   coef_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS:0]      forward_flow,
	output logic signed [SAMPLE_BITS:0]      reverse_flow
);
	import hfdds_pkg::*;

	localparam int AW   = $clog2(MAX_TAPS);
	localparam int CB   = COEF_FRAC_BITS + 1;
	localparam int PW   = SAMPLE_BITS + CB;
	localparam int ACCW = PW + AW;
	localparam int OW   = SAMPLE_BITS + 1;
	localparam int SW   = ACCW + 2;
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);
	localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [SW-1:0] OUT_MAX  = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [SW-1:0] OUT_MIN  = ~OUT_MAX;

	logic signed [SAMPLE_BITS-1:0] q_mem [MAX_TAPS];
	logic signed [CB-1:0]          c_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]           q_vld_q;
	logic [MAX_TAPS-1:0]           c_vld_q;

	logic [AW-1:0]                 wslot_q;
	logic [AW-1:0]                 qa_q;
	logic [AW-1:0]                 ca_q;
	logic [AW-1:0]                 cidx;
	logic                          cidx_ok;
	logic signed [SAMPLE_BITS-1:0] i_q;

	logic signed [SAMPLE_BITS-1:0] q_s1;
	logic signed [CB-1:0]          c_s1;
	logic                          en_s1;
	logic signed [PW-1:0]          prod_s2;
	logic                          en_s2;
	logic signed [ACCW-1:0]        acc_q;

	logic signed [SW-1:0]          hq;
	logic signed [SW-1:0]          fwd;
	logic signed [SW-1:0]          rev;
	logic signed [OW-1:0]          fwd_sat;
	logic signed [OW-1:0]          rev_sat;
	logic                          out_valid_q;
	logic signed [OW-1:0]          fwd_q;
	logic signed [OW-1:0]          rev_q;

	assign cidx    = AW'(coef_index);
	assign cidx_ok = 32'(coef_index) < 32'(MAX_TAPS);

	// stores: no reset, entries gated by valid bits
	always_ff @(posedge clk) begin
		if (dp_cmd.push) begin
			q_mem[wslot_q] <= q_sample;
		end
		q_s1 <= q_vld_q[qa_q] ? q_mem[qa_q] : '0;
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_coef && cidx_ok) begin
			c_mem[cidx] <= coef_value;
		end
		c_s1 <= c_vld_q[ca_q] ? c_mem[ca_q] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_q <= '0;
			c_vld_q <= '0;
			wslot_q <= '0;
		end else begin
			if (dp_cmd.clear_hist) begin
				q_vld_q <= '0;
				wslot_q <= '0;
			end else if (dp_cmd.push) begin
				q_vld_q[wslot_q] <= 1'b1;
				wslot_q <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + AW'(1);
			end
			if (dp_cmd.load_coef && cidx_ok) begin
				c_vld_q[cidx] <= 1'b1;
			end
		end
	end

	// tap pointers: newest Q against the last coefficient, both walking down
	always_ff @(posedge clk) begin
		if (dp_cmd.push) begin
			qa_q <= wslot_q;
			ca_q <= AW'(dp_cmd.taps - TAP_CNT_W'(1));
			i_q  <= i_sample;
		end else if (dp_cmd.issue) begin
			qa_q <= (qa_q == '0) ? LAST_SLOT : qa_q - AW'(1);
			ca_q <= ca_q - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
		end else begin
			en_s1 <= dp_cmd.issue;
			en_s2 <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s2 <= PW'(q_s1) * PW'(c_s1);
		end
		if (dp_cmd.push) begin
			acc_q <= '0;
		end else if (en_s2) begin
			acc_q <= acc_q + ACCW'(prod_s2);
		end
	end

	// round half up, floor shift, then exact sums and saturation
	always_comb begin
		hq  = (SW'(acc_q) + HALF_LSB) >>> COEF_FRAC_BITS;
		fwd = SW'(i_q) - hq;
		rev = SW'(i_q) + hq;
		if (fwd > OUT_MAX) begin
			fwd_sat = OW'(OUT_MAX);
		end else if (fwd < OUT_MIN) begin
			fwd_sat = OW'(OUT_MIN);
		end else begin
			fwd_sat = OW'(fwd);
		end
		if (rev > OUT_MAX) begin
			rev_sat = OW'(OUT_MAX);
		end else if (rev < OUT_MIN) begin
			rev_sat = OW'(OUT_MIN);
		end else begin
			rev_sat = OW'(rev);
		end
	end

	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			fwd_q <= fwd_sat;
			rev_q <= rev_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign forward_flow = fwd_q;
	assign reverse_flow = rev_q;

endmodule

/* design/hilbert_fir_doppler_direction_split.sv */
// Hilbert FIR Doppler direction splitter: forward = I - HQ, reverse = I + HQ.
// Sequence: after acceptance a sample transaction issues one MAC read per tap, drains
//   the product and accumulate stages, then rounds, saturates and loads its result.
// Samples are taken one at a time, as every tap shares the single multiplier: a new one
//   waits for the last result load; load-coefficient and clear transactions give no result.
// Reset: asynchronous, active low; history and coefficients read as zero, write slot
//   rewinds, tap count returns to 64. No clearing pass, the block is ready at once.
module hilbert_fir_doppler_direction_split #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tap count register
	input  logic                             cfg_wr_en,
	input  logic [hfdds_pkg::TAP_CNT_W-1:0]  cfg_wr_data,
	// input transactions
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [hfdds_pkg::CMD_W-1:0]      cmd,
	input  logic signed [SAMPLE_BITS-1:0]    i_sample,
	input  logic signed [SAMPLE_BITS-1:0]    q_sample,
	input  logic [hfdds_pkg::COEF_IDX_W-1:0] coef_index,
	input  logic signed [COEF_FRAC_BITS:0]   coef_value,
	// result transactions
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS:0]      forward_flow,
	output logic signed [SAMPLE_BITS:0]      reverse_flow
);
	import hfdds_pkg::*;

	dp_cmd_t dp_cmd;
	logic    res_free;

	// Controller: takes one transaction at a time. Commands retire in the
	// accepting cycle; samples walk the taps then wait for the result register.
	hfdds_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.res_free    (res_free),
		.dp_cmd      (dp_cmd)
	);

	// Datapath: the result register decouples output back-pressure, so the
	// next transaction is taken while a finished result is still waiting.
	hfdds_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.res_free     (res_free),
		.i_sample     (i_sample),
		.q_sample     (q_sample),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.forward_flow (forward_flow),
		.reverse_flow (reverse_flow)
	);

endmodule
